/* rtl/core/bcls_pkg.sv */
// shared types and constants for the battery current limit select block
package bcls_pkg;

	localparam int CUR_W  = 20;
	localparam int DIV_W  = 14;
	localparam int NUM_W  = CUR_W + DIV_W;
	localparam int VDIF_W = 13;
	localparam int COND_W = 16;
	localparam int VPRD_W = VDIF_W + COND_W;
	localparam int CFGI_W = 3;

	// divider: quotient bits per stage
	localparam int DIV_STEPS  = 5;

	// register indexes
	localparam logic [CFGI_W-1:0] REG_FULL_CURRENT = 3'd0;
	localparam logic [CFGI_W-1:0] REG_TEMP_WARN    = 3'd1;
	localparam logic [CFGI_W-1:0] REG_TEMP_FAULT   = 3'd2;
	localparam logic [CFGI_W-1:0] REG_SOC_WARN     = 3'd3;
	localparam logic [CFGI_W-1:0] REG_SOC_FAULT    = 3'd4;
	localparam logic [CFGI_W-1:0] REG_CUTOFF       = 3'd5;
	localparam logic [CFGI_W-1:0] REG_CONDUCTANCE  = 3'd6;

	// condition codes
	localparam logic [1:0] DCAUSE_NONE = 2'd0;
	localparam logic [1:0] DCAUSE_TEMP = 2'd1;
	localparam logic [1:0] DCAUSE_VOLT = 2'd2;
	localparam logic [1:0] DCAUSE_SOC  = 2'd3;
	localparam logic       CCAUSE_NONE = 1'b0;
	localparam logic       CCAUSE_TEMP = 1'b1;

	typedef struct packed {
		logic signed [7:0] max_temp_degc;
		logic [12:0]       min_ocv_mv;
		logic [13:0]       min_soc;
	} meas_t;

	typedef struct packed {
		logic [19:0] discharge_limit_ma;
		logic [19:0] charge_limit_ma;
		logic [1:0]  discharge_cause;
		logic        charge_cause;
		logic        limit_active;
	} limit_t;

	typedef struct packed {
		logic [19:0]       full_current_ma;
		logic signed [7:0] temp_warn_degc;
		logic signed [7:0] temp_fault_degc;
		logic [13:0]       soc_warn;
		logic [13:0]       soc_fault;
		logic [12:0]       cutoff_mv;
		logic [15:0]       conductance_a_per_v;
	} cfg_t;

	// long division state: partial remainder, numerator bits shifting into quotient, divisor
	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [CUR_W-1:0] nq;
		logic [DIV_W-1:0] dvs;
	} div_lane_t;

endpackage

/* rtl/core/bcls_prep.sv */
// front end: threshold tests, derating factors and the three products
module bcls_prep (
	input  logic                        clk,
	input  logic                        ld_s1,
	input  logic                        ld_s2,
	input  bcls_pkg::meas_t             meas,
	input  bcls_pkg::cfg_t              cfg,
	output bcls_pkg::div_lane_t         tlane,
	output bcls_pkg::div_lane_t         slane,
	output logic [bcls_pkg::VPRD_W-1:0] vprod
);

	logic signed [7:0] t;
	logic signed [7:0] warn;
	logic signed [7:0] fault;
	logic [7:0]        tdiff;
	logic [7:0]        tspan;
	logic [bcls_pkg::DIV_W-1:0] sdiff;
	logic [bcls_pkg::DIV_W-1:0] sspan;

	logic [bcls_pkg::DIV_W-1:0]  tfac_c, tdvs_c, sfac_c, sdvs_c;
	logic [bcls_pkg::VDIF_W-1:0] vdiff_c;

	logic [bcls_pkg::DIV_W-1:0]  tfac_s1, tdvs_s1, sfac_s1, sdvs_s1;
	logic [bcls_pkg::VDIF_W-1:0] vdiff_s1;

	logic [bcls_pkg::NUM_W-1:0]  tnum, snum;

	assign t     = meas.max_temp_degc;
	assign warn  = cfg.temp_warn_degc;
	assign fault = cfg.temp_fault_degc;
	// both differences are known to lie in 1..255 where they are used
	assign tdiff = fault - t;
	assign tspan = fault - warn;
	assign sdiff = meas.min_soc - cfg.soc_fault;
	assign sspan = cfg.soc_warn - cfg.soc_fault;

	// full and zero terms become full*1/1 and 0/1 so every lane divides
	always_comb begin
		if (t <= warn) begin
			tfac_c = bcls_pkg::DIV_W'(1);
			tdvs_c = bcls_pkg::DIV_W'(1);
		end else if (t >= fault) begin
			tfac_c = '0;
			tdvs_c = bcls_pkg::DIV_W'(1);
		end else begin
			tfac_c = bcls_pkg::DIV_W'(tdiff);
			tdvs_c = bcls_pkg::DIV_W'(tspan);
		end

		if (meas.min_soc >= cfg.soc_warn) begin
			sfac_c = bcls_pkg::DIV_W'(1);
			sdvs_c = bcls_pkg::DIV_W'(1);
		end else if (meas.min_soc <= cfg.soc_fault) begin
			sfac_c = '0;
			sdvs_c = bcls_pkg::DIV_W'(1);
		end else begin
			sfac_c = sdiff;
			sdvs_c = sspan;
		end

		if (meas.min_ocv_mv > cfg.cutoff_mv) begin
			vdiff_c = meas.min_ocv_mv - cfg.cutoff_mv;
		end else begin
			vdiff_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			tfac_s1  <= tfac_c;
			tdvs_s1  <= tdvs_c;
			sfac_s1  <= sfac_c;
			sdvs_s1  <= sdvs_c;
			vdiff_s1 <= vdiff_c;
		end
	end

	assign tnum = bcls_pkg::NUM_W'(cfg.full_current_ma) * bcls_pkg::NUM_W'(tfac_s1);
	assign snum = bcls_pkg::NUM_W'(cfg.full_current_ma) * bcls_pkg::NUM_W'(sfac_s1);

	// quotient fits in CUR_W bits, so the upper numerator bits already sit below the divisor
	always_ff @(posedge clk) begin
		if (ld_s2) begin
			tlane.rem <= tnum[bcls_pkg::NUM_W-1:bcls_pkg::CUR_W];
			tlane.nq  <= tnum[bcls_pkg::CUR_W-1:0];
			tlane.dvs <= tdvs_s1;
			slane.rem <= snum[bcls_pkg::NUM_W-1:bcls_pkg::CUR_W];
			slane.nq  <= snum[bcls_pkg::CUR_W-1:0];
			slane.dvs <= sdvs_s1;
			vprod     <= bcls_pkg::VPRD_W'(vdiff_s1) * bcls_pkg::VPRD_W'(cfg.conductance_a_per_v);
		end
	end

endmodule

/* rtl/core/bcls_div_stage.sv */
// one registered stage of restoring long division, a few quotient bits per stage
module bcls_div_stage (
	input  logic                clk,
	input  logic                ld,
	input  bcls_pkg::div_lane_t cur,
	output bcls_pkg::div_lane_t res
);

	logic [bcls_pkg::DIV_W-1:0] rem;
	logic [bcls_pkg::CUR_W-1:0] nq;
	logic [bcls_pkg::DIV_W:0]   trial;
	logic [bcls_pkg::DIV_W:0]   sub;

	always_comb begin
		rem   = cur.rem;
		nq    = cur.nq;
		trial = '0;
		sub   = '0;
		for (int i = 0; i < bcls_pkg::DIV_STEPS; i++) begin
			trial = {rem, nq[bcls_pkg::CUR_W-1]};
			sub   = trial - {1'b0, cur.dvs};
			nq    = {nq[bcls_pkg::CUR_W-2:0], 1'b0};
			if (trial >= {1'b0, cur.dvs}) begin
				rem   = sub[bcls_pkg::DIV_W-1:0];
				nq[0] = 1'b1;
			end else begin
				rem = trial[bcls_pkg::DIV_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			res.rem <= rem;
			res.nq  <= nq;
			res.dvs <= cur.dvs;
		end
	end

endmodule

/* rtl/core/bcls_select.sv */
// two stage minimum selection with first-term-wins ties, and the output register
module bcls_select (
	input  logic                       clk,
	input  logic                       ld_s7,
	input  logic                       ld_s8,
	input  logic [bcls_pkg::CUR_W-1:0] full,
	input  logic [bcls_pkg::CUR_W-1:0] tterm,
	input  logic [bcls_pkg::CUR_W-1:0] vterm,
	input  logic [bcls_pkg::CUR_W-1:0] sterm,
	output bcls_pkg::limit_t           res
);

	logic [bcls_pkg::CUR_W-1:0] amin_s7;
	logic                       acause_s7;
	logic [bcls_pkg::CUR_W-1:0] bmin_s7;
	logic [1:0]                 bcause_s7;

	// pair (full, temperature) and pair (voltage, charge)
	always_ff @(posedge clk) begin
		if (ld_s7) begin
			if (tterm < full) begin
				amin_s7   <= tterm;
				acause_s7 <= bcls_pkg::CCAUSE_TEMP;
			end else begin
				amin_s7   <= full;
				acause_s7 <= bcls_pkg::CCAUSE_NONE;
			end
			if (sterm < vterm) begin
				bmin_s7   <= sterm;
				bcause_s7 <= bcls_pkg::DCAUSE_SOC;
			end else begin
				bmin_s7   <= vterm;
				bcause_s7 <= bcls_pkg::DCAUSE_VOLT;
			end
		end
	end

	// discharge never exceeds charge, so its test alone sets limit_active
	always_ff @(posedge clk) begin
		if (ld_s8) begin
			res.charge_limit_ma <= amin_s7;
			res.charge_cause    <= acause_s7;
			if (bmin_s7 < amin_s7) begin
				res.discharge_limit_ma <= bmin_s7;
				res.discharge_cause    <= bcause_s7;
				res.limit_active       <= (bmin_s7 < full);
			end else begin
				res.discharge_limit_ma <= amin_s7;
				res.discharge_cause    <= (acause_s7 == bcls_pkg::CCAUSE_TEMP) ?
					bcls_pkg::DCAUSE_TEMP : bcls_pkg::DCAUSE_NONE;
				res.limit_active       <= (amin_s7 < full);
			end
		end
	end

endmodule

/* rtl/core/battery_current_limit_select.sv */
// top level of the battery current limit select block
//
// channel  direction  handshake            payload
// -------  ---------  -------------------  ------------------------------------
// meas     in         meas_valid/stall     hottest temp, lowest ocv, lowest soc
// limit    out        limit_valid/stall    charge/discharge limits, causes, flag
// cfg      in         cfg_valid/ready      cfg_index (0..6), cfg_data
//
// one transfer per cycle on meas and limit while nothing stalls; eight register stages
// limit_valid is the valid bit of the output register
// stages: tests, products, four divider stages of five quotient bits each,
// pair minimum, output register
// reset clears all valid bits and loads the register defaults
// a stall on limit freezes only full stages; empty slots keep filling
// cfg_ready is always high; the sender writes only while the pipeline is empty
module battery_current_limit_select (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        meas_valid,
	output logic                        meas_stall,
	input  bcls_pkg::meas_t             meas,
	output logic                        limit_valid,
	input  logic                        limit_stall,
	output bcls_pkg::limit_t            limit,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bcls_pkg::CFGI_W-1:0] cfg_index,
	input  logic [19:0]                 cfg_data
);

	// stage map: s1 tests, s2 products, s3..s6 division, s7 pair minimum, s8 output
	localparam int NSTG = 8;

	bcls_pkg::cfg_t cfg_q;

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] ld;
	logic [NSTG-1:0] vld_in;

	bcls_pkg::div_lane_t tlane_s2, tlane_s3, tlane_s4, tlane_s5, tlane_s6;
	bcls_pkg::div_lane_t slane_s2, slane_s3, slane_s4, slane_s5, slane_s6;
	logic [bcls_pkg::VPRD_W-1:0] vprod_s2;
	logic [bcls_pkg::CUR_W-1:0]  vterm_s3, vterm_s4, vterm_s5, vterm_s6;

	// configuration registers, to be written only while the pipeline is empty; the block does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_current_ma     <= 20'd265500;
			cfg_q.temp_warn_degc      <= 8'sd40;
			cfg_q.temp_fault_degc     <= 8'sd60;
			cfg_q.soc_warn            <= 14'd3000;
			cfg_q.soc_fault           <= 14'd2000;
			cfg_q.cutoff_mv           <= 13'd3550;
			cfg_q.conductance_a_per_v <= 16'd1200;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bcls_pkg::REG_FULL_CURRENT: cfg_q.full_current_ma     <= cfg_data;
				bcls_pkg::REG_TEMP_WARN:    cfg_q.temp_warn_degc      <= cfg_data[7:0];
				bcls_pkg::REG_TEMP_FAULT:   cfg_q.temp_fault_degc     <= cfg_data[7:0];
				bcls_pkg::REG_SOC_WARN:     cfg_q.soc_warn            <= cfg_data[13:0];
				bcls_pkg::REG_SOC_FAULT:    cfg_q.soc_fault           <= cfg_data[13:0];
				bcls_pkg::REG_CUTOFF:       cfg_q.cutoff_mv           <= cfg_data[12:0];
				bcls_pkg::REG_CONDUCTANCE:  cfg_q.conductance_a_per_v <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its content moves on
	always_comb begin
		ld[NSTG-1] = !vld_q[NSTG-1] || !limit_stall;
		for (int k = NSTG - 2; k >= 0; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	assign vld_in     = {vld_q[NSTG-2:0], meas_valid};
	assign meas_stall = !ld[0];
	assign limit_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NSTG; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	// s1, s2: threshold tests and products
	bcls_prep u_prep (
		.clk   (clk),
		.ld_s1 (ld[0]),
		.ld_s2 (ld[1]),
		.meas  (meas),
		.cfg   (cfg_q),
		.tlane (tlane_s2),
		.slane (slane_s2),
		.vprod (vprod_s2)
	);

	// s3..s6: temperature and charge divisions side by side
	bcls_div_stage u_tdiv3 (.clk(clk), .ld(ld[2]), .cur(tlane_s2), .res(tlane_s3));
	bcls_div_stage u_tdiv4 (.clk(clk), .ld(ld[3]), .cur(tlane_s3), .res(tlane_s4));
	bcls_div_stage u_tdiv5 (.clk(clk), .ld(ld[4]), .cur(tlane_s4), .res(tlane_s5));
	bcls_div_stage u_tdiv6 (.clk(clk), .ld(ld[5]), .cur(tlane_s5), .res(tlane_s6));

	bcls_div_stage u_sdiv3 (.clk(clk), .ld(ld[2]), .cur(slane_s2), .res(slane_s3));
	bcls_div_stage u_sdiv4 (.clk(clk), .ld(ld[3]), .cur(slane_s3), .res(slane_s4));
	bcls_div_stage u_sdiv5 (.clk(clk), .ld(ld[4]), .cur(slane_s4), .res(slane_s5));
	bcls_div_stage u_sdiv6 (.clk(clk), .ld(ld[5]), .cur(slane_s5), .res(slane_s6));

	// low voltage term saturates at the full current, then rides along the divider
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			if (vprod_s2 > bcls_pkg::VPRD_W'(cfg_q.full_current_ma)) begin
				vterm_s3 <= cfg_q.full_current_ma;
			end else begin
				vterm_s3 <= vprod_s2[bcls_pkg::CUR_W-1:0];
			end
		end
		if (ld[3]) begin
			vterm_s4 <= vterm_s3;
		end
		if (ld[4]) begin
			vterm_s5 <= vterm_s4;
		end
		if (ld[5]) begin
			vterm_s6 <= vterm_s5;
		end
	end

	// s7, s8: minimum selection and output register
	bcls_select u_select (
		.clk   (clk),
		.ld_s7 (ld[6]),
		.ld_s8 (ld[7]),
		.full  (cfg_q.full_current_ma),
		.tterm (tlane_s6.nq),
		.vterm (vterm_s6),
		.sterm (slane_s6.nq),
		.res   (limit)
	);

endmodule

/* dv/tb_battery_current_limit_select.sv */
// self-checking testbench for the battery current limit select block
module tb_battery_current_limit_select;
	timeunit 1ns;
	timeprecision 1ps;

	// register index outside the list, a write to it must change nothing
	localparam logic [bcls_pkg::CFGI_W-1:0] REG_UNUSED = 3'd7;
	// pipeline depth from the block header, plus margin
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASES        = 10;
	localparam int SETS_PER_PHASE = 125;

	// tracks the register file, predicts the limits of each accepted
	// measurement set and checks them against the limit transfers
	class limit_tracker;
		longint full_ma;
		int     t_warn, t_fault;
		int     s_warn, s_fault;
		int     cutoff, cond;
		bcls_pkg::limit_t pending_limits[$];
		int     errors;
		int     checked;
		int     cause_seen[4];

		function new();
			full_ma = 265500;
			t_warn  = 40;
			t_fault = 60;
			s_warn  = 3000;
			s_fault = 2000;
			cutoff  = 3550;
			cond    = 1200;
			errors  = 0;
			checked = 0;
			foreach (cause_seen[i]) cause_seen[i] = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void set_reg(logic [bcls_pkg::CFGI_W-1:0] idx, logic [19:0] data);
			case (idx)
				bcls_pkg::REG_FULL_CURRENT: full_ma = data;
				bcls_pkg::REG_TEMP_WARN:    t_warn  = $signed(data[7:0]);
				bcls_pkg::REG_TEMP_FAULT:   t_fault = $signed(data[7:0]);
				bcls_pkg::REG_SOC_WARN:     s_warn  = data[13:0];
				bcls_pkg::REG_SOC_FAULT:    s_fault = data[13:0];
				bcls_pkg::REG_CUTOFF:       cutoff  = data[12:0];
				bcls_pkg::REG_CONDUCTANCE:  cond    = data[15:0];
				default:          ;
			endcase
		endfunction

		function bcls_pkg::limit_t calc_limits(bcls_pkg::meas_t m);
			bcls_pkg::limit_t r;
			int     t, ocv, soc;
			longint temp_ma, volt_ma, soc_ma, dis, chg;
			logic [1:0] dcause;
			logic       ccause;
			t   = $signed(m.max_temp_degc);
			ocv = m.min_ocv_mv;
			soc = m.min_soc;
			// warning test first, so a zero or inverted span is a step
			if (t <= t_warn)
				temp_ma = full_ma;
			else if (t >= t_fault)
				temp_ma = 0;
			else
				temp_ma = (full_ma * (t_fault - t)) / (t_fault - t_warn);
			if (soc >= s_warn)
				soc_ma = full_ma;
			else if (soc <= s_fault)
				soc_ma = 0;
			else
				soc_ma = (full_ma * (soc - s_fault)) / (s_warn - s_fault);
			if (ocv <= cutoff)
				volt_ma = 0;
			else begin
				volt_ma = longint'(ocv - cutoff) * cond;
				if (volt_ma > full_ma) volt_ma = full_ma;
			end
			// strictly smaller replaces, earlier term wins a tie
			dis = full_ma;
			dcause = bcls_pkg::DCAUSE_NONE;
			if (temp_ma < dis) begin
				dis = temp_ma;
				dcause = bcls_pkg::DCAUSE_TEMP;
			end
			if (volt_ma < dis) begin
				dis = volt_ma;
				dcause = bcls_pkg::DCAUSE_VOLT;
			end
			if (soc_ma < dis) begin
				dis = soc_ma;
				dcause = bcls_pkg::DCAUSE_SOC;
			end
			chg = full_ma;
			ccause = bcls_pkg::CCAUSE_NONE;
			if (temp_ma < chg) begin
				chg = temp_ma;
				ccause = bcls_pkg::CCAUSE_TEMP;
			end
			r.discharge_limit_ma = 20'(dis);
			r.charge_limit_ma    = 20'(chg);
			r.discharge_cause    = dcause;
			r.charge_cause       = ccause;
			r.limit_active       = (dis < full_ma) || (chg < full_ma);
			return r;
		endfunction

		function void note_meas(bcls_pkg::meas_t m);
			pending_limits.push_back(calc_limits(m));
		endfunction

		task check_limit(bcls_pkg::limit_t got);
			bcls_pkg::limit_t want;
			if (pending_limits.size() == 0) begin
				report($sformatf("limit transfer with nothing outstanding: %h", got));
			end else begin
				want = pending_limits.pop_front();
				checked++;
				cause_seen[want.discharge_cause]++;
				if (got.discharge_limit_ma !== want.discharge_limit_ma)
					report($sformatf("discharge_limit_ma expected %0d got %0d",
						want.discharge_limit_ma, got.discharge_limit_ma));
				if (got.charge_limit_ma !== want.charge_limit_ma)
					report($sformatf("charge_limit_ma expected %0d got %0d",
						want.charge_limit_ma, got.charge_limit_ma));
				if (got.discharge_cause !== want.discharge_cause)
					report($sformatf("discharge_cause expected %0d got %0d",
						want.discharge_cause, got.discharge_cause));
				if (got.charge_cause !== want.charge_cause)
					report($sformatf("charge_cause expected %0d got %0d",
						want.charge_cause, got.charge_cause));
				if (got.limit_active !== want.limit_active)
					report($sformatf("limit_active expected %0d got %0d",
						want.limit_active, got.limit_active));
			end
		endtask

		function int outstanding();
			return pending_limits.size();
		endfunction
	endclass

	// block ports, every input known from time zero
	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        meas_valid = 1'b0;
	logic                        meas_stall;
	bcls_pkg::meas_t             meas = '0;
	logic                        limit_valid;
	logic                        limit_stall = 1'b0;
	bcls_pkg::limit_t            limit;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [bcls_pkg::CFGI_W-1:0] cfg_index = '0;
	logic [19:0]                 cfg_data = '0;

	// idle rates in percent for the sender and the receiver
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int settings_done  = 0;

	limit_tracker tracker = new();

	battery_current_limit_select DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.meas_valid  (meas_valid),
		.meas_stall  (meas_stall),
		.meas        (meas),
		.limit_valid (limit_valid),
		.limit_stall (limit_stall),
		.limit       (limit),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#5ms;
		$display("tb_battery_current_limit_select failed");
		$finish;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		limit_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
	end

	// monitor: values read at the edge are the pre-edge ones, since every
	// driver here and in the block updates through nonblocking assignments
	always @(posedge clk) begin
		if (arst_n) begin
			if (limit_valid && !limit_stall) tracker.check_limit(limit);
			if (meas_valid && !meas_stall) tracker.note_meas(meas);
			if (cfg_valid && cfg_ready) tracker.set_reg(cfg_index, cfg_data);
		end
	end

	// one measurement transfer; valid stays up across back-to-back sets
	task automatic send_meas(bcls_pkg::meas_t m);
		while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
			meas_valid <= 1'b0;
			@(posedge clk);
		end
		meas_valid <= 1'b1;
		meas <= m;
		do @(posedge clk); while (meas_stall);
	endtask

	task automatic send_set(int t, int ocv, int soc);
		bcls_pkg::meas_t m;
		m.max_temp_degc = 8'(t);
		m.min_ocv_mv    = 13'(ocv);
		m.min_soc       = 14'(soc);
		send_meas(m);
	endtask

	// stop sending and let every outstanding limit come out
	task automatic drain();
		meas_valid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write; the caller lowers cfg_valid after the last one
	task automatic write_reg(logic [bcls_pkg::CFGI_W-1:0] idx, logic [19:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(int full, int tw, int tf, int sw, int sf, int co, int cd);
		write_reg(bcls_pkg::REG_FULL_CURRENT, 20'(full));
		write_reg(bcls_pkg::REG_TEMP_WARN,    20'(8'(tw)));
		write_reg(bcls_pkg::REG_TEMP_FAULT,   20'(8'(tf)));
		write_reg(bcls_pkg::REG_SOC_WARN,     20'(14'(sw)));
		write_reg(bcls_pkg::REG_SOC_FAULT,    20'(14'(sf)));
		write_reg(bcls_pkg::REG_CUTOFF,       20'(13'(co)));
		write_reg(bcls_pkg::REG_CONDUCTANCE,  20'(16'(cd)));
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	// random measurement set: a quarter fully random, the rest placed
	// around the thresholds of the current settings
	function automatic bcls_pkg::meas_t rand_meas();
		bcls_pkg::meas_t m;
		int    lim;
		m.max_temp_degc = 8'($urandom);
		m.min_ocv_mv    = 13'($urandom);
		m.min_soc       = 14'($urandom);
		if ($urandom_range(3) != 0) begin
			case ($urandom_range(2))
				0: m.max_temp_degc = 8'(tracker.t_warn + int'($urandom_range(4)) - 2);
				1: m.max_temp_degc = 8'(tracker.t_fault + int'($urandom_range(4)) - 2);
				default: begin
					if (tracker.t_fault > tracker.t_warn)
						m.max_temp_degc = 8'(tracker.t_warn
							+ int'($urandom_range(tracker.t_fault - tracker.t_warn)));
				end
			endcase
			// ocv from just below cutoff up to a little past saturation
			lim = (tracker.cond == 0) ? 8 : int'(tracker.full_ma / tracker.cond) + 2;
			if (lim > 8191) lim = 8191;
			m.min_ocv_mv = 13'(tracker.cutoff + int'($urandom_range(lim)) - 1);
			if (tracker.s_warn > tracker.s_fault)
				m.min_soc = 14'(tracker.s_fault - 1
					+ int'($urandom_range(tracker.s_warn - tracker.s_fault + 2)));
			else
				m.min_soc = 14'(tracker.s_warn + int'($urandom_range(4)) - 2);
		end
		return m;
	endfunction

	// settings for one phase: fixed extremes first, random afterwards
	task automatic phase_settings(int phase);
		int tw, tf, sw, sf;
		case (phase)
			0: begin
				// a write to an unused index, then the reset values written back
				write_reg(REG_UNUSED, 20'($urandom));
				load_settings(265500, 40, 60, 3000, 2000, 3550, 1200);
			end
			// widest spans, no cutoff, strongest conductance
			1: load_settings(1000000, -128, 127, 10000, 0, 0, 65535);
			// inverted spans, all-ones current and cutoff, no conductance
			2: load_settings(20'hFFFFF, 127, -128, 0, 16383, 8191, 0);
			3: begin
				// zero spans step at the warning threshold; zero full current
				tw = int'($urandom_range(255)) - 128;
				sw = $urandom_range(10000);
				load_settings(0, tw, tw, sw, sw, $urandom_range(5000), $urandom);
			end
			4: load_settings(1, 0, 1, 1, 0, 4999, 1);
			default: begin
				tw = int'($urandom_range(120)) - 60;
				tf = tw + int'($urandom_range(40));
				sf = $urandom_range(8000);
				sw = sf + int'($urandom_range(2000));
				if ($urandom_range(4) == 0) tf = int'($urandom_range(255)) - 128;
				if ($urandom_range(4) == 0) sw = $urandom_range(16383);
				load_settings(($urandom_range(1) != 0) ? $urandom : $urandom_range(1000000),
					tw, tf, sw, sf, $urandom_range(8191), $urandom_range(65535));
			end
		endcase
	endtask

	initial begin
		// reset held from the start, released once and never again
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 16;
		recv_stall_pct = 54;

		// directed sets at the reset settings
		send_set(-128, 0, 0);
		send_set(127, 8191, 16383);
		send_set(40, 5000, 10000);          // at warning temperature, all full
		send_set(41, 5000, 10000);
		send_set(50, 5000, 10000);
		send_set(59, 5000, 10000);
		send_set(60, 5000, 10000);          // at fault temperature
		send_set(25, 3550, 10000);          // ocv at cutoff
		send_set(25, 3551, 10000);
		send_set(25, 3771, 10000);          // just under saturation
		send_set(25, 3772, 10000);          // saturates, ties with full
		send_set(25, 5000, 3000);           // charge at warning
		send_set(25, 5000, 2999);
		send_set(25, 5000, 2001);
		send_set(25, 5000, 2000);           // charge at fault
		send_set(50, 5000, 2500);           // temperature and charge tie
		send_set(50, 3661, 2500);           // low voltage just over both
		send_set(55, 3661, 2400);
		send_set(45, 5000, 2100);
		send_set(60, 3550, 2000);           // every term at zero
		send_set(-1, 4095, 8191);
		send_set(0, 2048, 4096);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			// sender idles lightly and receiver heavily, then swapped, then none
			if (phase == 4) begin
				send_idle_pct  = 54;
				recv_stall_pct = 16;
			end else if (phase == 7) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			phase_settings(phase);
			for (int n = 0; n < SETS_PER_PHASE; n++) begin
				send_meas(rand_meas());
				// in phase 5 the sender holds off mid-phase until the pipeline is empty
				if (phase == 5 && n == SETS_PER_PHASE / 2) drain();
			end
			drain();
		end

		$display("checked %0d limit transfers over %0d register settings",
			tracker.checked, settings_done);
		$display("discharge set by none/temperature/voltage/charge: %0d/%0d/%0d/%0d",
			tracker.cause_seen[bcls_pkg::DCAUSE_NONE], tracker.cause_seen[bcls_pkg::DCAUSE_TEMP],
			tracker.cause_seen[bcls_pkg::DCAUSE_VOLT], tracker.cause_seen[bcls_pkg::DCAUSE_SOC]);
		if (tracker.errors == 0)
			$display("tb_battery_current_limit_select passed");
		else
			$display("tb_battery_current_limit_select failed");
		$finish;
	end

endmodule
